FILE: design/rtcm2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtcm2_pkg;

   localparam int unsigned WORD_W      = 30;
   localparam int unsigned DATA_W      = 24;
   localparam int unsigned PAR_W       = 6;
   localparam int unsigned BODY_W      = 63;
   localparam int unsigned BODY_CNT_W  = 6;
   localparam int unsigned REC_W       = 40;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [2:0] PIECES_PER_WORD = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREAMBLE   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECODE_ALL = 4'd1;

   localparam logic [7:0] PREAMBLE_RESET   = 8'h66;
   localparam logic       DECODE_ALL_RESET = 1'b1;

   localparam logic [5:0] TYPE_DIFF_CORR    = 6'd1;
   localparam logic [5:0] TYPE_PARTIAL_CORR = 6'd9;

   localparam logic [DATA_W-1:0] PMASK_D25 = 24'hEC7CD2;
   localparam logic [DATA_W-1:0] PMASK_D26 = 24'h763E69;
   localparam logic [DATA_W-1:0] PMASK_D27 = 24'hBB1F34;
   localparam logic [DATA_W-1:0] PMASK_D28 = 24'h5D8F9A;
   localparam logic [DATA_W-1:0] PMASK_D29 = 24'hAEC7CD;
   localparam logic [DATA_W-1:0] PMASK_D30 = 24'h2DEA27;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_CORR      = 3'd1,
      KIND_CORR_END  = 3'd2,
      KIND_FRAME_END = 3'd3,
      KIND_PARITY    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_HUNT    = 3'b001,
      MODE_CONFIRM = 3'b010,
      MODE_BODY    = 3'b100
   } mode_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] data;
   } check_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_wr_type;

   typedef struct packed {
      kind_type           kind;
      logic [5:0]         msg_type;
      logic [9:0]         station_id;
      logic [12:0]        z_count;
      logic [2:0]         seq_no;
      logic [4:0]         frame_len;
      logic [2:0]         health;
      logic [5:0]         sat_id;
      logic [2:0]         scale_udre;
      logic signed [15:0] prc;
      logic signed [7:0]  rrc;
      logic [7:0]         iod;
   } result_type;

   // D25..D30 of 24 data bits, D25 in bit 5; prev is {D29*, D30*}
   function automatic logic [PAR_W-1:0] gps_parity(input logic [DATA_W-1:0] data,
                                                   input logic [1:0] prev);
      logic [PAR_W-1:0] p;
      p[5] = prev[1] ^ (^(data & PMASK_D25));
      p[4] = prev[0] ^ (^(data & PMASK_D26));
      p[3] = prev[1] ^ (^(data & PMASK_D27));
      p[2] = prev[0] ^ (^(data & PMASK_D28));
      p[1] = prev[0] ^ (^(data & PMASK_D29));
      p[0] = prev[1] ^ (^(data & PMASK_D30));
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: design/rtcm2_word_check.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcm2_word_check (
   input  wire logic [rtcm2_pkg::WORD_W-1:0] word,
   input  wire logic [1:0]                   prev,
   output rtcm2_pkg::check_type              check
);
   import rtcm2_pkg::*;

   logic [DATA_W-1:0] data;

   // prior D30 set means the data bits went out inverted
   assign data       = word[WORD_W-1:PAR_W] ^ {DATA_W{prev[0]}};
   assign check.data = data;
   assign check.ok   = (gps_parity(data, prev) == word[PAR_W-1:0]);

endmodule

`default_nettype wire

FILE: design/rtcm2_decode_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcm2_decode_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             in_byte,
   input  rtcm2_pkg::csr_wr_type       csr_wr,
   output logic                        res_valid,
   output rtcm2_pkg::result_type       res
);
   import rtcm2_pkg::*;

   logic [7:0]            preamble_ff, preamble_in;
   logic                  decode_all_ff, decode_all_in;
   mode_type              mode_ff, mode_in;
   logic [WORD_W-1:0]     shift_ff, shift_in;
   logic [2:0]            piece_ff, piece_in;
   logic [1:0]            prev_ff, prev_in;
   logic [15:0]           hdr_ff, hdr_in;
   logic [4:0]            left_ff, left_in;
   logic [BODY_W-1:0]     body_ff, body_in;
   logic [BODY_CNT_W-1:0] bcnt_ff, bcnt_in;
   logic [5:0]            ftype_ff, ftype_in;

   logic                  hunting;
   logic [1:0]            prev_use;
   logic [WORD_W-1:0]     shift_new;
   logic [2:0]            piece_new;
   check_type             check;
   logic [4:0]            left_dec;
   logic                  decode;
   logic [BODY_W-1:0]     body_cat;
   logic [BODY_CNT_W-1:0] cnt_add, cnt_sub;
   logic [REC_W-1:0]      rec;

   assign hunting   = (mode_ff != MODE_CONFIRM) && (mode_ff != MODE_BODY);
   assign prev_use  = (hunting && piece_ff >= PIECES_PER_WORD) ? shift_ff[25:24] : prev_ff;
   assign shift_new = {shift_ff[WORD_W-PAR_W-1:0],
                       in_byte[0], in_byte[1], in_byte[2],
                       in_byte[3], in_byte[4], in_byte[5]};
   assign piece_new = (piece_ff < PIECES_PER_WORD) ? 3'(piece_ff + 3'd1) : piece_ff;

   rtcm2_word_check u_check (
      .word  (shift_new),
      .prev  (prev_use),
      .check (check)
   );

   assign left_dec = 5'(left_ff - 5'd1);
   assign decode   = decode_all_ff || ftype_ff == TYPE_DIFF_CORR
                     || ftype_ff == TYPE_PARTIAL_CORR;
   assign body_cat = {body_ff[BODY_W-DATA_W-1:0], check.data};
   assign cnt_add  = BODY_CNT_W'(bcnt_ff + BODY_CNT_W'(DATA_W));
   assign cnt_sub  = BODY_CNT_W'(cnt_add - BODY_CNT_W'(REC_W));
   assign rec      = REC_W'(body_cat >> cnt_sub);

   always_comb begin
      preamble_in   = preamble_ff;
      decode_all_in = decode_all_ff;
      mode_in       = mode_ff;
      shift_in      = shift_ff;
      piece_in      = piece_ff;
      prev_in       = prev_ff;
      hdr_in        = hdr_ff;
      left_in       = left_ff;
      body_in       = body_ff;
      bcnt_in       = bcnt_ff;
      ftype_in      = ftype_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (csr_wr.valid) begin
         if (csr_wr.index == CSR_PREAMBLE) begin
            preamble_in = csr_wr.wdata;
         end else if (csr_wr.index == CSR_DECODE_ALL) begin
            decode_all_in = csr_wr.wdata[0];
         end
      end

      if (step && in_byte[7:6] == 2'b01) begin
         prev_in  = prev_use;
         shift_in = shift_new;
         piece_in = piece_new;
         if (piece_new >= PIECES_PER_WORD) begin
            unique case (mode_ff)
               MODE_CONFIRM: begin
                  if (!check.ok) begin
                     mode_in  = MODE_HUNT;
                     piece_in = PIECES_PER_WORD;
                     left_in  = '0;
                     body_in  = '0;
                     bcnt_in  = '0;
                  end else begin
                     prev_in        = shift_new[1:0];
                     ftype_in       = hdr_ff[15:10];
                     res_valid      = 1'b1;
                     res.kind       = KIND_HEADER;
                     res.msg_type   = hdr_ff[15:10];
                     res.station_id = hdr_ff[9:0];
                     res.z_count    = check.data[23:11];
                     res.seq_no     = check.data[10:8];
                     res.frame_len  = check.data[7:3];
                     res.health     = check.data[2:0];
                     piece_in       = '0;
                     body_in        = '0;
                     bcnt_in        = '0;
                     left_in        = check.data[7:3];
                     mode_in        = (check.data[7:3] != 5'd0) ? MODE_BODY : MODE_HUNT;
                  end
               end
               MODE_BODY: begin
                  if (!check.ok) begin
                     mode_in   = MODE_HUNT;
                     piece_in  = PIECES_PER_WORD;
                     left_in   = '0;
                     body_in   = '0;
                     bcnt_in   = '0;
                     res_valid = 1'b1;
                     res.kind  = KIND_PARITY;
                  end else begin
                     piece_in = '0;
                     prev_in  = shift_new[1:0];
                     left_in  = left_dec;
                     if (decode) begin
                        body_in = body_cat;
                        bcnt_in = cnt_add;
                     end
                     if (decode && cnt_add >= BODY_CNT_W'(REC_W)) begin
                        // keep only the bits not yet taken into a record
                        body_in        = body_cat & ~({BODY_W{1'b1}} << cnt_sub);
                        bcnt_in        = cnt_sub;
                        res_valid      = 1'b1;
                        res.kind       = (left_dec == 5'd0) ? KIND_CORR_END : KIND_CORR;
                        res.sat_id     = (rec[36:32] == 5'd0) ? 6'd32 : {1'b0, rec[36:32]};
                        res.scale_udre = rec[39:37];
                        res.prc        = rec[31:16];
                        res.rrc        = rec[15:8];
                        res.iod        = rec[7:0];
                        if (left_dec == 5'd0) begin
                           mode_in = MODE_HUNT;
                           body_in = '0;
                           bcnt_in = '0;
                        end
                     end else if (left_dec == 5'd0) begin
                        mode_in   = MODE_HUNT;
                        body_in   = '0;
                        bcnt_in   = '0;
                        res_valid = 1'b1;
                        res.kind  = KIND_FRAME_END;
                     end
                  end
               end
               default: begin
                  if (check.ok && check.data[23:16] == preamble_ff) begin
                     hdr_in   = check.data[15:0];
                     prev_in  = shift_new[1:0];
                     mode_in  = MODE_CONFIRM;
                     piece_in = '0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff   <= PREAMBLE_RESET;
         decode_all_ff <= DECODE_ALL_RESET;
         mode_ff       <= MODE_HUNT;
         shift_ff      <= '0;
         piece_ff      <= '0;
         prev_ff       <= 2'b11;
         left_ff       <= '0;
         body_ff       <= '0;
         bcnt_ff       <= '0;
         ftype_ff      <= '0;
      end else begin
         preamble_ff   <= preamble_in;
         decode_all_ff <= decode_all_in;
         mode_ff       <= mode_in;
         shift_ff      <= shift_in;
         piece_ff      <= piece_in;
         prev_ff       <= prev_in;
         left_ff       <= left_in;
         body_ff       <= body_in;
         bcnt_ff       <= bcnt_in;
         ftype_ff      <= ftype_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

`default_nettype wire

FILE: design/rtcm2_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// A byte passes the input stage, then its result word, if any, goes to the
// result register that drives rsp_valid. Throughput: one byte per cycle while
// no result waits on rsp_ready; the input stage and the result register are
// separate, so one byte is still taken into an empty input stage while a result waits on rsp_ready.
// The byte decode is combinational XOR/shift logic between the two registers.
// Reset (synchronous, active high) returns to hunting with registers at defaults.
module rtcm2_frame_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_in_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [2:0]                                rsp_kind,
   output logic [5:0]                                rsp_msg_type,
   output logic [9:0]                                rsp_station_id,
   output logic [12:0]                               rsp_z_count,
   output logic [2:0]                                rsp_seq_no,
   output logic [4:0]                                rsp_frame_len,
   output logic [2:0]                                rsp_health,
   output logic [5:0]                                rsp_sat_id,
   output logic [2:0]                                rsp_scale_udre,
   output logic signed [15:0]                        rsp_prc,
   output logic signed [7:0]                         rsp_rrc,
   output logic [7:0]                                rsp_iod,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [rtcm2_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rtcm2_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rtcm2_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       advance;
   logic       res_valid;
   result_type res;
   csr_wr_type csr_wr;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.wdata = csr_wdata;

   rtcm2_decode_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (in_byte_ff),
      .csr_wr    (csr_wr),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_msg_type   = rsp_ff.msg_type;
   assign rsp_station_id = rsp_ff.station_id;
   assign rsp_z_count    = rsp_ff.z_count;
   assign rsp_seq_no     = rsp_ff.seq_no;
   assign rsp_frame_len  = rsp_ff.frame_len;
   assign rsp_health     = rsp_ff.health;
   assign rsp_sat_id     = rsp_ff.sat_id;
   assign rsp_scale_udre = rsp_ff.scale_udre;
   assign rsp_prc        = rsp_ff.prc;
   assign rsp_rrc        = rsp_ff.rrc;
   assign rsp_iod        = rsp_ff.iod;

endmodule

`default_nettype wire

FILE: bench/tb_rtcm2_frame_decoder.sv
`timescale 1ns / 1ps

module tb_rtcm2_frame_decoder;

   import rtcm2_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_COUNT = 5;
   localparam int WORDS_PER_PHASE = 210;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 4'd15;

   typedef struct {
      logic [7:0] b;
      bit         typed;
      bit         has_res;
      result_type res;
   } byte_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [5:0] rsp_msg_type;
   logic [9:0] rsp_station_id;
   logic [12:0] rsp_z_count;
   logic [2:0] rsp_seq_no;
   logic [4:0] rsp_frame_len;
   logic [2:0] rsp_health;
   logic [5:0] rsp_sat_id;
   logic [2:0] rsp_scale_udre;
   logic signed [15:0] rsp_prc;
   logic signed [7:0] rsp_rrc;
   logic [7:0] rsp_iod;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rtcm2_frame_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_msg_type(rsp_msg_type),
      .rsp_station_id(rsp_station_id),
      .rsp_z_count(rsp_z_count),
      .rsp_seq_no(rsp_seq_no),
      .rsp_frame_len(rsp_frame_len),
      .rsp_health(rsp_health),
      .rsp_sat_id(rsp_sat_id),
      .rsp_scale_udre(rsp_scale_udre),
      .rsp_prc(rsp_prc),
      .rsp_rrc(rsp_rrc),
      .rsp_iod(rsp_iod),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder model state and its copy of the registers
   mode_type    pr_mode;
   logic [29:0] pr_shift;
   int          pr_pieces;
   logic [1:0]  pr_prev;
   logic [23:0] pr_hdr1;
   logic [4:0]  pr_left;
   logic [62:0] pr_body;
   int          pr_nbits;
   logic [5:0]  pr_ftype;
   logic [7:0]  cfg_preamble;
   logic        cfg_decode_all;

   // last two stream bits on the line, seeds parity of the next encoded word
   logic [1:0] enc_last2;

   result_type   expected_results[$];
   byte_row_type byte_rows[$];
   int errors = 0;
   int valid_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int ready_mode = 0;
   int ready_run = 0;
   int ready_tick = 0;

   function automatic logic [5:0] rev6(input logic [5:0] v);
      logic [5:0] r;
      for (int i = 0; i < 6; i++) r[i] = v[5-i];
      return r;
   endfunction

   // D25..D30, D25 in bit 5; last = {D29, D30} of the prior word
   function automatic logic [5:0] word_parity(input logic [23:0] d, input logic [1:0] last);
      logic [5:0] p;
      p[5] = last[1] ^ (^(d & 24'hEC7CD2));
      p[4] = last[0] ^ (^(d & 24'h763E69));
      p[3] = last[1] ^ (^(d & 24'hBB1F34));
      p[2] = last[0] ^ (^(d & 24'h5D8F9A));
      p[1] = last[0] ^ (^(d & 24'hAEC7CD));
      p[0] = last[1] ^ (^(d & 24'h2DEA27));
      return p;
   endfunction

   function automatic void back_to_hunt(input int pieces);
      pr_mode = MODE_HUNT;
      pr_pieces = pieces;
      pr_left = '0;
      pr_body = '0;
      pr_nbits = 0;
   endfunction

   function automatic void init_model();
      cfg_preamble = PREAMBLE_RESET;
      cfg_decode_all = DECODE_ALL_RESET;
      pr_shift = '0;
      pr_prev = 2'b11;
      pr_hdr1 = '0;
      pr_ftype = '0;
      back_to_hunt(0);
      enc_last2 = 2'b11;
   endfunction

   // returns 1 when the byte yields a result word
   function automatic bit decode_byte(input logic [7:0] b, output result_type r);
      logic [23:0] data;
      logic        ok;
      logic [39:0] rec;
      logic [4:0]  sat;
      bit          dec;
      r = '0;
      if (b[7:6] != 2'b01) return 0;
      if (pr_mode == MODE_HUNT && pr_pieces >= 5) pr_prev = pr_shift[25:24];
      pr_shift = {pr_shift[23:0], rev6(b[5:0])};
      if (pr_pieces < 5) pr_pieces++;
      if (pr_pieces < 5) return 0;
      data = pr_shift[29:6];
      if (pr_prev[0]) data = ~data;
      ok = (word_parity(data, pr_prev) == pr_shift[5:0]);
      case (pr_mode)
         MODE_CONFIRM: begin
            if (!ok) begin
               back_to_hunt(5);
               return 0;
            end
            pr_prev = pr_shift[1:0];
            pr_ftype = pr_hdr1[15:10];
            r.kind = KIND_HEADER;
            r.msg_type = pr_ftype;
            r.station_id = pr_hdr1[9:0];
            r.z_count = data[23:11];
            r.seq_no = data[10:8];
            r.frame_len = data[7:3];
            r.health = data[2:0];
            back_to_hunt(0);
            pr_left = data[7:3];
            if (pr_left != 0) pr_mode = MODE_BODY;
            return 1;
         end
         MODE_BODY: begin
            dec = cfg_decode_all || pr_ftype == TYPE_DIFF_CORR || pr_ftype == TYPE_PARTIAL_CORR;
            if (!ok) begin
               back_to_hunt(5);
               r.kind = KIND_PARITY;
               return 1;
            end
            pr_pieces = 0;
            pr_prev = pr_shift[1:0];
            pr_left = pr_left - 5'd1;
            if (dec) begin
               pr_body = (pr_body << 24) | 63'(data);
               pr_nbits += 24;
               if (pr_nbits >= 40) begin
                  rec = 40'(pr_body >> (pr_nbits - 40));
                  pr_nbits -= 40;
                  pr_body &= (63'd1 << pr_nbits) - 63'd1;
                  if (pr_left == 0) r.kind = KIND_CORR_END;
                  else r.kind = KIND_CORR;
                  sat = rec[36:32];
                  r.sat_id = (sat == 0) ? 6'd32 : {1'b0, sat};
                  r.scale_udre = rec[39:37];
                  r.prc = rec[31:16];
                  r.rrc = rec[15:8];
                  r.iod = rec[7:0];
                  if (pr_left == 0) back_to_hunt(0);
                  return 1;
               end
            end
            if (pr_left == 0) begin
               back_to_hunt(0);
               r.kind = KIND_FRAME_END;
               return 1;
            end
            return 0;
         end
         default: begin
            if (ok && data[23:16] == cfg_preamble) begin
               pr_hdr1 = data;
               pr_prev = pr_shift[1:0];
               pr_mode = MODE_CONFIRM;
               pr_pieces = 0;
            end
            return 0;
         end
      endcase
   endfunction

   function automatic void add_row(input logic [7:0] b, input bit typed, input bit has_res,
                                   input result_type res);
      byte_row_type row;
      row.b = b;
      row.typed = typed;
      row.has_res = has_res;
      row.res = res;
      byte_rows.push_back(row);
   endfunction

   function automatic void tag_last(input result_type res);
      byte_rows[byte_rows.size()-1].typed = 1'b1;
      byte_rows[byte_rows.size()-1].has_res = 1'b1;
      byte_rows[byte_rows.size()-1].res = res;
   endfunction

   // top bits 00, 10 or 11: the decoder drops these
   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b01) b[7] = 1'b1;
      return b;
   endfunction

   function automatic void noise_byte();
      logic [7:0] b;
      logic [5:0] piece;
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b01) begin
         piece = rev6(b[5:0]);
         enc_last2 = piece[1:0];
      end
      add_row(b, 1'b0, 1'b0, '0);
   endfunction

   function automatic void emit_word(input logic [23:0] data, input bit corrupt, input bit junk);
      logic [29:0] w;
      w = {(enc_last2[0] ? ~data : data), word_parity(data, enc_last2)};
      if (corrupt) w[$urandom_range(0, 29)] ^= 1'b1;
      for (int k = 0; k < 5; k++) begin
         if (junk && $urandom_range(0, 24) == 0) add_row(junk_byte(), 1'b0, 1'b0, '0);
         add_row({2'b01, rev6(w[29-6*k -: 6])}, 1'b0, 1'b0, '0);
      end
      enc_last2 = w[1:0];
   endfunction

   function automatic void load_directed();
      result_type res;
      logic [39:0] rec;
      add_row(8'h00, 1'b1, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b0, '0);
      // zero-length frame, header fields at their maximum
      emit_word({PREAMBLE_RESET, 6'd63, 10'd1023}, 1'b0, 1'b0);
      emit_word({13'h1FFF, 3'd7, 5'd0, 3'd7}, 1'b0, 1'b0);
      res = '0;
      res.kind = KIND_HEADER;
      res.msg_type = 6'd63;
      res.station_id = 10'd1023;
      res.z_count = 13'h1FFF;
      res.seq_no = 3'd7;
      res.health = 3'd7;
      tag_last(res);
      // type 1 frame, two words, one record with extreme fields and raw sat 0
      emit_word({PREAMBLE_RESET, TYPE_DIFF_CORR, 10'd0}, 1'b0, 1'b0);
      emit_word({13'd0, 3'd0, 5'd2, 3'd0}, 1'b0, 1'b0);
      res = '0;
      res.kind = KIND_HEADER;
      res.msg_type = TYPE_DIFF_CORR;
      res.frame_len = 5'd2;
      tag_last(res);
      rec = {1'b1, 2'b11, 5'd0, 16'h8000, 8'h7F, 8'hFF};
      emit_word(rec[39:16], 1'b0, 1'b0);
      emit_word({rec[15:0], 8'h00}, 1'b0, 1'b0);
      res = '0;
      res.kind = KIND_CORR_END;
      res.sat_id = 6'd32;
      res.scale_udre = 3'd7;
      res.prc = -16'sd32768;
      res.rrc = 8'sd127;
      res.iod = 8'hFF;
      tag_last(res);
   endfunction

   // one random chunk: a line-noise burst, or a frame with an occasional bad word
   function automatic void load_random_chunk();
      logic [7:0]  pre;
      logic [5:0]  mt;
      logic [9:0]  stn;
      logic [12:0] zc;
      logic [2:0]  sq, hl;
      logic [4:0]  len;
      int          sel;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 12)) noise_byte();
         return;
      end
      pre = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : cfg_preamble;
      if ($urandom_range(0, 4) < 2) mt = $urandom_range(0, 1) ? TYPE_DIFF_CORR : TYPE_PARTIAL_CORR;
      else mt = 6'($urandom_range(0, 63));
      stn = 10'($urandom_range(0, 1023));
      zc = 13'($urandom_range(0, 8191));
      sq = 3'($urandom_range(0, 7));
      hl = 3'($urandom_range(0, 7));
      sel = $urandom_range(0, 99);
      if (sel < 70) len = 5'($urandom_range(0, 3));
      else if (sel < 94) len = 5'($urandom_range(4, 10));
      else if (sel < 97) len = 5'($urandom_range(11, 30));
      else len = 5'd31;
      emit_word({pre, mt, stn}, $urandom_range(0, 29) == 0, 1'b1);
      emit_word({zc, sq, len, hl}, $urandom_range(0, 24) == 0, 1'b1);
      repeat (len) emit_word(24'($urandom()), $urandom_range(0, 59) == 0, 1'b1);
   endfunction

   task automatic send_rows();
      byte_row_type row;
      result_type   res;
      bit           has;
      while (byte_rows.size() != 0) begin
         row = byte_rows.pop_front();
         req_valid <= 1'b1;
         req_in_byte <= row.b;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         has = decode_byte(row.b, res);
         if (row.typed) begin
            has = row.has_res;
            res = row.res;
         end
         if (has) expected_results.push_back(res);
         if (row.b[7:6] == 2'b01) valid_sent++;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clock);
            else repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_PREAMBLE) cfg_preamble = val;
      else if (idx == CSR_DECODE_ALL) cfg_decode_all = val[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, kind %0d", $time, rsp_kind);
         end else begin
            want = expected_results.pop_front();
            check_field("kind", int'(want.kind), int'(rsp_kind));
            check_field("msg_type", int'(want.msg_type), int'(rsp_msg_type));
            check_field("station_id", int'(want.station_id), int'(rsp_station_id));
            check_field("z_count", int'(want.z_count), int'(rsp_z_count));
            check_field("seq_no", int'(want.seq_no), int'(rsp_seq_no));
            check_field("frame_len", int'(want.frame_len), int'(rsp_frame_len));
            check_field("health", int'(want.health), int'(rsp_health));
            check_field("sat_id", int'(want.sat_id), int'(rsp_sat_id));
            check_field("scale_udre", int'(want.scale_udre), int'(rsp_scale_udre));
            check_field("prc", int'(want.prc), int'(rsp_prc));
            check_field("rrc", int'(want.rrc), int'(rsp_rrc));
            check_field("iod", int'(want.iod), int'(rsp_iod));
         end
      end
   end

   // receiver: always ready, coin flip, mostly stalled, or a fixed 3-of-8 duty
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_run = $urandom_range(20, 200);
      end else begin
         ready_run--;
      end
      ready_tick++;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((ready_tick % 8) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      init_model();
      burst_left = $urandom_range(1, 12);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      send_rows();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph != 0) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clock);
            case (ph)
               1: begin
                  write_reg(CSR_PREAMBLE, 8'h00);
                  write_reg(CSR_DECODE_ALL, 8'h00);
               end
               2: begin
                  write_reg(CSR_PREAMBLE, 8'hFF);
                  write_reg(CSR_DECODE_ALL, 8'h01);
                  write_reg(CSR_SPARE_HIGH, 8'($urandom_range(0, 255)));
               end
               3: begin
                  write_reg(CSR_PREAMBLE, 8'($urandom_range(0, 255)));
                  write_reg(CSR_DECODE_ALL, 8'hFE);
               end
               default: begin
                  write_reg(CSR_SPARE_LOW, 8'($urandom_range(0, 255)));
                  write_reg(CSR_PREAMBLE, PREAMBLE_RESET);
                  write_reg(CSR_DECODE_ALL, 8'h01);
               end
            endcase
         end
         valid_sent = 0;
         while (valid_sent < WORDS_PER_PHASE) begin
            load_random_chunk();
            send_rows();
            // hold off now and then until every result is out
            if ($urandom_range(0, 29) == 0) drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES + 2) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
